// File: sv/svbc_pkg.sv
// ----------------------------------------------------------------------------
// svbc_pkg
// Shared types, constants and the element type table for the strided view
// bounds checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svbc_pkg;

  localparam int INDEX_WIDTH = 64;
  // Largest legal element index, zero-extended to 64 bits.
  localparam logic [63:0] INDEX_MAX = 64'((65'd1 << INDEX_WIDTH) - 65'd1);

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_TYPE   = 3'd1,
    ERR_STRIDE_OVF = 3'd2,
    ERR_OFFSET_OVF = 3'd3,
    ERR_SIZE_OVF   = 3'd4,
    ERR_TOO_SMALL  = 3'd5
  } err_code_t;

  // {bad, log2 of element bytes}, indexed by element type code
  localparam logic [2:0] TYPE_BAD = 3'b100;
  localparam logic [2:0] TYPE_DECODE [16] = '{
    3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd1, 3'd2, TYPE_BAD,
    TYPE_BAD, TYPE_BAD, TYPE_BAD, 3'd0, TYPE_BAD, TYPE_BAD, TYPE_BAD, 3'd1
  };

  // Per-beat sideband that travels alongside the multiplier
  typedef struct packed {
    logic        has_dim;
    logic        size_zero;
    logic        first;
    logic        last;
    logic        bad_type;
    logic [1:0]  size_log2;
    logic        offset_ovf;
    logic [62:0] offset;
    logic [63:0] storage;
  } item_t;

  // Partial products of (size - 1) * stride
  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  // Final view state handed to the result stage
  typedef struct packed {
    err_code_t   code;
    logic        empty;
    logic [1:0]  size_log2;
    logic [63:0] last_index;
    logic [63:0] storage;
  } view_t;

endpackage

// File: sv/svbc_if.sv
// ----------------------------------------------------------------------------
// svbc_item_if / svbc_result_if
// Valid/ready channels for dimension beats and check results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface svbc_item_if;
  logic        valid;
  logic        ready;
  logic        has_dim;
  logic [62:0] dim_size;
  logic [62:0] dim_stride;
  logic        first_dim;
  logic        last_dim;
  logic [3:0]  element_type;
  logic [62:0] view_offset;
  logic [63:0] storage_bytes;

  modport source (
    output valid, has_dim, dim_size, dim_stride, first_dim, last_dim,
           element_type, view_offset, storage_bytes,
    input  ready
  );
  modport sink (
    input  valid, has_dim, dim_size, dim_stride, first_dim, last_dim,
           element_type, view_offset, storage_bytes,
    output ready
  );
endinterface

interface svbc_result_if;
  logic        valid;
  logic        ready;
  logic        view_ok;
  logic [2:0]  error_code;
  logic [63:0] required_bytes;

  modport source (output valid, view_ok, error_code, required_bytes, input ready);
  modport sink (input valid, view_ok, error_code, required_bytes, output ready);
endinterface

// File: sv/svbc_mul.sv
// ----------------------------------------------------------------------------
// svbc_mul
// Registered 32x32 partial products of (size - 1) * stride.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svbc_mul import svbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  input  logic [63:0] mul_a,
  input  logic [63:0] mul_b,
  output logic        out_valid,
  input  logic        out_ready,
  output item_t       out_item,
  output pp_t         out_pp
);

  logic  valid;
  item_t item;
  pp_t   pp;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;
  assign out_pp    = pp;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item  <= in_item;
      pp.ll <= mul_a[31:0]  * mul_b[31:0];
      pp.lh <= mul_a[31:0]  * mul_b[63:32];
      pp.hl <= mul_a[63:32] * mul_b[31:0];
      pp.hh <= mul_a[63:32] * mul_b[63:32];
    end
  end

endmodule

// File: sv/svbc_acc.sv
// ----------------------------------------------------------------------------
// svbc_acc
// Span overflow check and last-index accumulation; holds the per-view state
// and registers the finished view on the last beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svbc_acc import svbc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  pp_t   in_pp,
  output logic  out_valid,
  input  logic  out_ready,
  output view_t out_view
);

  logic [63:0] last_index, last_index_next;
  logic        view_empty, view_empty_next;
  err_code_t   error_latch, error_latch_next;
  logic [1:0]  element_size_log2, element_size_log2_next;

  logic        done;
  view_t       view;

  logic [63:0] mid;
  logic [63:0] span;
  logic        span_ovf;
  logic        fire;

  logic [63:0] base_index;
  logic        base_empty;
  err_code_t   base_err;
  logic [1:0]  base_log2;

  // Only a last beat needs room downstream
  assign in_ready  = !in_item.last || !done || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = done;
  assign out_view  = view;

  // High half is nonzero iff any term feeding it is; no wrap is possible
  assign mid      = {32'd0, in_pp.ll[63:32]} + {32'd0, in_pp.lh[31:0]}
                  + {32'd0, in_pp.hl[31:0]};
  assign span     = {mid[31:0], in_pp.ll[31:0]};
  assign span_ovf = (in_pp.hh != 64'd0) || (in_pp.lh[63:32] != 32'd0)
                 || (in_pp.hl[63:32] != 32'd0) || (mid[63:32] != 32'd0)
                 || (span > INDEX_MAX);

  always_comb begin
    base_index = last_index;
    base_empty = view_empty;
    base_err   = error_latch;
    base_log2  = element_size_log2;
    if (in_item.first) begin
      base_empty = 1'b0;
      base_index = 64'd0;
      base_log2  = 2'd0;
      if (in_item.bad_type) begin
        base_err = ERR_BAD_TYPE;
      end else begin
        base_log2 = in_item.size_log2;
        if (in_item.offset_ovf) begin
          base_err = ERR_OFFSET_OVF;
        end else begin
          base_err   = ERR_NONE;
          base_index = {1'b0, in_item.offset};
        end
      end
    end
  end

  always_comb begin
    last_index_next        = base_index;
    view_empty_next        = base_empty;
    error_latch_next       = base_err;
    element_size_log2_next = base_log2;
    if (in_item.has_dim && base_err == ERR_NONE && !base_empty) begin
      priority if (in_item.size_zero) begin
        view_empty_next = 1'b1;
      end else if (span_ovf) begin
        error_latch_next = ERR_STRIDE_OVF;
      end else if (base_index > INDEX_MAX - span) begin
        error_latch_next = ERR_OFFSET_OVF;
      end else begin
        last_index_next = base_index + span;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_index        <= 64'd0;
      view_empty        <= 1'b0;
      error_latch       <= ERR_NONE;
      element_size_log2 <= 2'd0;
      done              <= 1'b0;
    end else begin
      if (fire) begin
        if (in_item.last) begin
          // state returns to reset after every result
          last_index        <= 64'd0;
          view_empty        <= 1'b0;
          error_latch       <= ERR_NONE;
          element_size_log2 <= 2'd0;
        end else begin
          last_index        <= last_index_next;
          view_empty        <= view_empty_next;
          error_latch       <= error_latch_next;
          element_size_log2 <= element_size_log2_next;
        end
      end
      if (fire && in_item.last) begin
        done <= 1'b1;
      end else if (out_ready) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_item.last) begin
      view.code       <= error_latch_next;
      view.empty      <= view_empty_next;
      view.size_log2  <= element_size_log2_next;
      view.last_index <= last_index_next;
      view.storage    <= in_item.storage;
    end
  end

endmodule

// File: sv/svbc_res.sv
// ----------------------------------------------------------------------------
// svbc_res
// Byte requirement, size and storage checks; drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svbc_res import svbc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  view_t         in_view,
  svbc_result_if.source result
);

  logic        valid;
  logic        ok;
  err_code_t   code;
  logic [63:0] bytes;

  err_code_t   code_c;
  logic [63:0] need;
  logic [64:0] count;
  logic [63:0] limit;

  assign in_ready = !valid || result.ready;

  assign result.valid          = valid;
  assign result.view_ok        = ok;
  assign result.error_code     = code;
  assign result.required_bytes = bytes;

  assign count = {1'b0, in_view.last_index} + 65'd1;
  assign limit = INDEX_MAX >> in_view.size_log2;

  always_comb begin
    code_c = in_view.code;
    need   = 64'd0;
    if (code_c == ERR_NONE && !in_view.empty) begin
      if (in_view.last_index >= INDEX_MAX || count > {1'b0, limit}) begin
        code_c = ERR_SIZE_OVF;
      end else begin
        need = count[63:0] << in_view.size_log2;
      end
    end
    if (code_c == ERR_NONE && need > in_view.storage) begin
      code_c = ERR_TOO_SMALL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ok    <= (code_c == ERR_NONE);
      code  <= code_c;
      bytes <= (code_c == ERR_NONE || code_c == ERR_TOO_SMALL) ? need : 64'd0;
    end
  end

endmodule

// File: sv/strided_view_bounds_checker_unit.sv
// ----------------------------------------------------------------------------
// strided_view_bounds_checker_unit
// Checks a strided view (one beat per dimension, or one scalar beat) against
// its backing storage and reports the bytes needed and the first error. The
// unit takes one beat per cycle, including back-to-back views, unless a held
// result backs up the pipeline. Each beat flows through an input register,
// a stage of four registered 32x32 partial products of (size - 1) * stride
// and an accumulate stage whose single 64-bit add and compare is the only
// loop from beat to beat; a view's result is then registered in the result
// stage. Beats keep being taken while a result waits; a beat that is not
// the last of a view only stops behind a full pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strided_view_bounds_checker_unit import svbc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  svbc_item_if.sink     item,
  svbc_result_if.source result
);

  logic        valid;
  item_t       stage;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        stage_ready;

  item_t       item_c;
  logic [2:0]  type_code;

  logic        mul_valid;
  logic        mul_ready;
  item_t       mul_item;
  pp_t         mul_pp;

  logic        view_valid;
  logic        view_ready;
  view_t       view;

  assign item.ready = !valid || stage_ready;
  assign type_code  = TYPE_DECODE[item.element_type];

  always_comb begin
    item_c.has_dim    = item.has_dim;
    item_c.size_zero  = (item.dim_size == 63'd0);
    item_c.first      = item.first_dim;
    item_c.last       = item.last_dim;
    item_c.bad_type   = type_code[2];
    item_c.size_log2  = type_code[1:0];
    item_c.offset_ovf = ({1'b0, item.view_offset} > INDEX_MAX);
    item_c.offset     = item.view_offset;
    item_c.storage    = item.storage_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item.ready) begin
      valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      stage <= item_c;
      mul_a <= {1'b0, item.dim_size} - 64'd1;
      mul_b <= {1'b0, item.dim_stride};
    end
  end

  svbc_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid),
    .in_ready  (stage_ready),
    .in_item   (stage),
    .mul_a     (mul_a),
    .mul_b     (mul_b),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_item  (mul_item),
    .out_pp    (mul_pp)
  );

  svbc_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_item   (mul_item),
    .in_pp     (mul_pp),
    .out_valid (view_valid),
    .out_ready (view_ready),
    .out_view  (view)
  );

  svbc_res u_res (
    .clk      (clk),
    .rst      (rst),
    .in_valid (view_valid),
    .in_ready (view_ready),
    .in_view  (view),
    .result   (result)
  );

endmodule

// File: sv/svbc_checker.sv
// ----------------------------------------------------------------------------
// svbc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svbc_checker import svbc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        view_ok,
  input logic [2:0]  error_code,
  input logic [63:0] required_bytes
);

  // a stalled result beat stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_clear_on_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (view_ok == (error_code == ERR_NONE)))
    else $error("view_ok disagrees with error_code");

  a_no_bytes_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code == ERR_BAD_TYPE || error_code == ERR_STRIDE_OVF ||
                  error_code == ERR_OFFSET_OVF || error_code == ERR_SIZE_OVF)
    |-> required_bytes == 64'd0)
    else $error("required_bytes nonzero on overflow or type error");

endmodule

bind strided_view_bounds_checker_unit svbc_checker u_svbc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .view_ok        (result.view_ok),
  .error_code     (result.error_code),
  .required_bytes (result.required_bytes)
);
